// ===== rtl/core/afd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afd_pkg: shared types and constants of the aspect-fit downscaler
// Holds the configuration register map, reset sizes and the selection flags
// that pass from the position tracker to the output stage.
// ----------------------------------------------------------------------------
package afd_pkg;

  // Width of each size register and of the register index.
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  // Register map of the configuration channel.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_BOX_WIDTH  = 2'd2,
    REG_BOX_HEIGHT = 2'd3
  } cfg_reg_t;

  // Size registers after reset.
  localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 13'd480;
  localparam logic [CFG_W-1:0] RST_BOX_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_BOX_HEIGHT = 13'd480;

  // Decision for the pixel being accepted.
  typedef struct packed {
    logic hit;   // pixel is forwarded
    logic last;  // pixel closes the output frame
  } afd_sel_t;

endpackage
`default_nettype wire

// ===== rtl/core/afd_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afd_div: restoring divider, one quotient bit per cycle
// Divides an unsigned numerator by a non-zero unsigned denominator. A start
// pulse loads the operands; done pulses once the quotient is complete.
// ----------------------------------------------------------------------------
module afd_div #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 13
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_next;
  logic             take;

  always_comb begin
    rem_sh   = {rem, quotient[NUM_W-1]};
    take     = rem_sh >= {1'b0, den_r};
    rem_next = take ? rem_sh - {1'b0, den_r} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && cnt == CNT_W'(NUM_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= num;
      rem      <= '0;
      den_r    <= den;
      cnt      <= '0;
    end else if (running) begin
      quotient <= {quotient[NUM_W-2:0], take};
      rem      <= rem_next[DEN_W-1:0];
      cnt      <= cnt + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/afd_fit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afd_fit: box fitting and step factor sequencer
// Recomputes the fitted size and the fixed-point step factors from the size
// registers after reset and after every register write, sharing one divider.
// ----------------------------------------------------------------------------
module afd_fit
  import afd_pkg::*;
#(
  parameter int MAX_DIM_BITS = 12,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           restart,
  input  wire logic [CFG_W-1:0]               src_width,
  input  wire logic [CFG_W-1:0]               src_height,
  input  wire logic [CFG_W-1:0]               box_width,
  input  wire logic [CFG_W-1:0]               box_height,
  output logic                                busy,
  output logic [MAX_DIM_BITS:0]               live_sw,
  output logic [MAX_DIM_BITS:0]               live_sh,
  output logic [MAX_DIM_BITS:0]               fitted_w,
  output logic [MAX_DIM_BITS:0]               fitted_h,
  output logic [MAX_DIM_BITS+FRAC_BITS-1:0]   col_step,
  output logic [MAX_DIM_BITS+FRAC_BITS-1:0]   row_step
);

  localparam int DIM_W  = MAX_DIM_BITS + 1;
  localparam int STEP_W = MAX_DIM_BITS + FRAC_BITS;
  localparam int PROD_W = 2 * DIM_W;
  localparam int SNUM_W = DIM_W + FRAC_BITS;
  localparam int NUM_W  = (PROD_W > SNUM_W) ? PROD_W : SNUM_W;
  localparam int EXT_W  = (CFG_W > DIM_W) ? CFG_W : DIM_W;
  localparam int TOP    = 1 << MAX_DIM_BITS;

  typedef enum logic [3:0] {
    S_PREP,
    S_MUL,
    S_FIT_GO,
    S_FIT_WAIT,
    S_CLAMP,
    S_COL_GO,
    S_COL_WAIT,
    S_ROW_GO,
    S_ROW_WAIT,
    S_DONE
  } fit_state_t;

  fit_state_t        state;
  logic [DIM_W-1:0]  sw_r, sh_r, bw_r, bh_r;
  logic [DIM_W-1:0]  fw_r, fh_r;
  logic [PROD_W-1:0] prod_a, prod_b;
  logic [STEP_W-1:0] cstep_r, rstep_r;

  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [DIM_W-1:0]  div_den;
  logic              div_done;
  logic [NUM_W-1:0]  div_q;

  // Zero reads as one, anything past the largest frame reads as the largest.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [EXT_W-1:0] vx;
    vx = EXT_W'(v);
    if (vx == '0) begin
      return DIM_W'(1);
    end else if (vx > EXT_W'(TOP)) begin
      return DIM_W'(TOP);
    end
    return DIM_W'(vx);
  endfunction

  // Fitted size is at least one and never above the source size.
  function automatic logic [DIM_W-1:0] clamp_fit(input logic [DIM_W-1:0] f,
                                                 input logic [DIM_W-1:0] s);
    if (f == '0) begin
      return DIM_W'(1);
    end else if (f > s) begin
      return s;
    end
    return f;
  endfunction

  function automatic logic [STEP_W-1:0] sat_step(input logic [NUM_W-1:0] q);
    if (|q[NUM_W-1:STEP_W]) begin
      return '1;
    end
    return q[STEP_W-1:0];
  endfunction

  always_comb begin
    live_sw = eff_dim(src_width);
    live_sh = eff_dim(src_height);
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state)
      S_FIT_GO: begin
        div_start = 1'b1;
        if (prod_a > prod_b) begin
          div_num = NUM_W'(prod_b);
          div_den = sh_r;
        end else begin
          div_num = NUM_W'(prod_a);
          div_den = sw_r;
        end
      end
      S_COL_GO: begin
        div_start = 1'b1;
        div_num   = NUM_W'({sw_r, {FRAC_BITS{1'b0}}});
        div_den   = fw_r;
      end
      S_ROW_GO: begin
        div_start = 1'b1;
        div_num   = NUM_W'({sh_r, {FRAC_BITS{1'b0}}});
        div_den   = fh_r;
      end
      default: begin
      end
    endcase
  end

  afd_div #(
    .NUM_W (NUM_W),
    .DEN_W (DIM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_PREP;
    end else if (restart) begin
      state <= S_PREP;
    end else begin
      unique case (state)
        S_PREP: begin
          sw_r  <= live_sw;
          sh_r  <= live_sh;
          bw_r  <= eff_dim(box_width);
          bh_r  <= eff_dim(box_height);
          state <= S_MUL;
        end
        S_MUL: begin
          prod_a <= PROD_W'(bw_r) * PROD_W'(sh_r);
          prod_b <= PROD_W'(bh_r) * PROD_W'(sw_r);
          state  <= S_FIT_GO;
        end
        S_FIT_GO: begin
          fw_r  <= bw_r;
          fh_r  <= bh_r;
          state <= (prod_a == prod_b) ? S_CLAMP : S_FIT_WAIT;
        end
        S_FIT_WAIT: begin
          if (div_done) begin
            if (prod_a > prod_b) begin
              fw_r <= div_q[DIM_W-1:0];
            end else begin
              fh_r <= div_q[DIM_W-1:0];
            end
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          fw_r  <= clamp_fit(fw_r, sw_r);
          fh_r  <= clamp_fit(fh_r, sh_r);
          state <= S_COL_GO;
        end
        S_COL_GO: begin
          state <= S_COL_WAIT;
        end
        S_COL_WAIT: begin
          if (div_done) begin
            cstep_r <= sat_step(div_q);
            state   <= S_ROW_GO;
          end
        end
        S_ROW_GO: begin
          state <= S_ROW_WAIT;
        end
        S_ROW_WAIT: begin
          if (div_done) begin
            rstep_r <= sat_step(div_q);
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_DONE;
        end
        default: begin
          state <= S_PREP;
        end
      endcase
    end
  end

  always_comb begin
    busy     = state != S_DONE;
    fitted_w = fw_r;
    fitted_h = fh_r;
    col_step = cstep_r;
    row_step = rstep_r;
  end

endmodule
`default_nettype wire

// ===== rtl/core/afd_pos.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afd_pos: source position and selection tracker
// Follows the raster position of the incoming pixels and the fixed-point
// positions of the next source column and row to pick.
// ----------------------------------------------------------------------------
module afd_pos
  import afd_pkg::*;
#(
  parameter int MAX_DIM_BITS = 12,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               accept,
  input  wire logic [MAX_DIM_BITS:0]              live_sw,
  input  wire logic [MAX_DIM_BITS:0]              live_sh,
  input  wire logic [MAX_DIM_BITS:0]              new_fw,
  input  wire logic [MAX_DIM_BITS:0]              new_fh,
  input  wire logic [MAX_DIM_BITS+FRAC_BITS-1:0]  new_cstep,
  input  wire logic [MAX_DIM_BITS+FRAC_BITS-1:0]  new_rstep,
  output afd_sel_t                                sel
);

  localparam int POS_W  = MAX_DIM_BITS;
  localparam int DIM_W  = MAX_DIM_BITS + 1;
  localparam int STEP_W = MAX_DIM_BITS + FRAC_BITS;
  localparam int ACC_W  = STEP_W + 1;

  logic [POS_W-1:0]  src_col, src_row;
  logic [ACC_W-1:0]  col_acc, row_acc;
  logic [DIM_W-1:0]  out_col, out_row;
  logic [DIM_W-1:0]  act_fw, act_fh;
  logic [STEP_W-1:0] act_cstep, act_rstep;

  logic              at_start;
  logic [DIM_W-1:0]  fw_c, fh_c, oc_c, or_c;
  logic [STEP_W-1:0] cstep_c, rstep_c;
  logic [ACC_W-1:0]  cacc_c, racc_c;
  logic              col_sel, row_sel;
  logic              row_end, frame_done;

  always_comb begin
    // The first pixel of a frame takes the fresh fit and restarts the counts.
    at_start = (src_col == '0) && (src_row == '0);
    fw_c     = at_start ? new_fw    : act_fw;
    fh_c     = at_start ? new_fh    : act_fh;
    cstep_c  = at_start ? new_cstep : act_cstep;
    rstep_c  = at_start ? new_rstep : act_rstep;
    cacc_c   = at_start ? '0 : col_acc;
    racc_c   = at_start ? '0 : row_acc;
    oc_c     = at_start ? '0 : out_col;
    or_c     = at_start ? '0 : out_row;

    col_sel = (oc_c < fw_c) && (cacc_c[ACC_W-1:FRAC_BITS] == DIM_W'(src_col));
    row_sel = (or_c < fh_c) && (racc_c[ACC_W-1:FRAC_BITS] == DIM_W'(src_row));

    sel.hit  = col_sel && row_sel;
    sel.last = ({1'b0, or_c} + 1'b1 == {1'b0, fh_c}) &&
               ({1'b0, oc_c} + 1'b1 == {1'b0, fw_c});

    row_end    = DIM_W'(src_col) + 1'b1 >= live_sw;
    frame_done = DIM_W'(src_row) + 1'b1 >= live_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col <= '0;
      src_row <= '0;
      col_acc <= '0;
      row_acc <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (accept) begin
      if (row_end) begin
        src_col <= '0;
        out_col <= '0;
        col_acc <= '0;
        if (frame_done) begin
          src_row <= '0;
          out_row <= '0;
          row_acc <= '0;
        end else begin
          src_row <= src_row + 1'b1;
          out_row <= row_sel ? or_c + 1'b1 : or_c;
          row_acc <= row_sel ? racc_c + ACC_W'(rstep_c) : racc_c;
        end
      end else begin
        src_col <= src_col + 1'b1;
        out_col <= col_sel ? oc_c + 1'b1 : oc_c;
        col_acc <= col_sel ? cacc_c + ACC_W'(cstep_c) : cacc_c;
        out_row <= or_c;
        row_acc <= racc_c;
      end
    end
  end

  // Fit and steps hold for the whole frame once its first pixel is taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_fw    <= fw_c;
      act_fh    <= fh_c;
      act_cstep <= cstep_c;
      act_rstep <= rstep_c;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/aspect_fit_nearest_downscaler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aspect_fit_nearest_downscaler: aspect-preserving nearest-neighbor shrink
// Takes a raster frame one pixel per beat and forwards the pixels that a
// nearest-neighbor downscale to the aspect-fitted box selects.
// ----------------------------------------------------------------------------
// The block accepts one source pixel per clock in raster order and forwards
// each selected pixel unchanged, with frame_end marking the last pixel of the
// output frame. The box is shrunk to the source aspect ratio and the column
// and row step factors are fixed point with FRAC_BITS fraction bits; both are
// taken at the first pixel of every frame, while the live source size closes
// rows and frames. After reset and after every configuration write, a shared
// restoring divider recomputes the fit and the two steps, one quotient bit
// per cycle over three divisions; the fit division is not waited for when
// the box already has the source's shape. The divider is NUM_W bits wide,
// the larger of 2 * MAX_DIM_BITS + 2 and MAX_DIM_BITS + FRAC_BITS + 1.
// in_stall stays high while the recompute runs and during the beat of a
// configuration write. Otherwise each pixel is decided in the cycle it is
// accepted and its beat is held in an output register backed by a one-beat
// skid register, so the input keeps taking one pixel per clock while a
// result waits; in_stall rises only when both are full. Size registers read
// zero as one and clip at 2^MAX_DIM_BITS. The block never enlarges: a fitted
// side larger than the source is cut to the source size.
module aspect_fit_nearest_downscaler
  import afd_pkg::*;
#(
  parameter int MAX_DIM_BITS = 12,
  parameter int FRAC_BITS    = 16,
  parameter int PIXEL_BITS   = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Source pixel channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIXEL_BITS-1:0] pixel_in,
  // Output pixel channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [PIXEL_BITS-1:0]      pixel_out,
  output logic                       frame_end,
  // Configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  localparam int DIM_W  = MAX_DIM_BITS + 1;
  localparam int STEP_W = MAX_DIM_BITS + FRAC_BITS;

  logic [CFG_W-1:0]      src_width, src_height, box_width, box_height;
  logic                  cfg_wr;

  logic                  fit_busy;
  logic [DIM_W-1:0]      live_sw, live_sh, fitted_w, fitted_h;
  logic [STEP_W-1:0]     col_step, row_step;

  logic                  in_accept;
  afd_sel_t              sel;

  logic                  skid_valid;
  logic [PIXEL_BITS-1:0] skid_pixel;
  logic                  skid_end;
  logic                  out_free;

  // Writes are always taken; the recompute that follows holds off pixels.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= RST_SRC_WIDTH;
      src_height <= RST_SRC_HEIGHT;
      box_width  <= RST_BOX_WIDTH;
      box_height <= RST_BOX_HEIGHT;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
        REG_BOX_WIDTH:  box_width  <= cfg_data;
        REG_BOX_HEIGHT: box_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  afd_fit #(
    .MAX_DIM_BITS (MAX_DIM_BITS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_fit (
    .clk        (clk),
    .rst        (rst),
    .restart    (cfg_wr),
    .src_width  (src_width),
    .src_height (src_height),
    .box_width  (box_width),
    .box_height (box_height),
    .busy       (fit_busy),
    .live_sw    (live_sw),
    .live_sh    (live_sh),
    .fitted_w   (fitted_w),
    .fitted_h   (fitted_h),
    .col_step   (col_step),
    .row_step   (row_step)
  );

  // The skid register only fills while the output register is held, so a
  // full skid is the one case where the next pixel has nowhere to go.
  assign in_stall  = fit_busy || skid_valid || cfg_valid;
  assign in_accept = in_valid && !in_stall;

  afd_pos #(
    .MAX_DIM_BITS (MAX_DIM_BITS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_pos (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .live_sw   (live_sw),
    .live_sh   (live_sh),
    .new_fw    (fitted_w),
    .new_fh    (fitted_h),
    .new_cstep (col_step),
    .new_rstep (row_step),
    .sel       (sel)
  );

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      // Output register moves on: refill from the skid first, else take the
      // decision for the pixel accepted this cycle.
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept && sel.hit;
      end
    end else if (in_accept && sel.hit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        pixel_out <= skid_pixel;
        frame_end <= skid_end;
      end else begin
        pixel_out <= pixel_in;
        frame_end <= sel.last;
      end
    end else if (in_accept && sel.hit) begin
      skid_pixel <= pixel_in;
      skid_end   <= sel.last;
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb_aspect_fit_nearest_downscaler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_aspect_fit_nearest_downscaler: self-checking bench for the downscaler
// Streams raster frames under many size settings, predicts which pixels the
// aspect-fitted nearest-neighbor shrink keeps, and checks every output beat.
// ----------------------------------------------------------------------------
module tb_aspect_fit_nearest_downscaler;
  import afd_pkg::*;

  localparam int DIM_BITS  = 12;
  localparam int FRAC_BITS = 16;
  localparam int PIX_BITS  = 32;
  localparam int STEP_W    = DIM_BITS + FRAC_BITS;

  localparam logic [CFG_W-1:0] DIM_TOP  = CFG_W'(1) << DIM_BITS;
  localparam longint unsigned  STEP_MAX = (64'd1 << STEP_W) - 1;

  // Run shaping. The block decides each pixel in its accept cycle, so the quiet
  // settle before touching the size registers has no decision pipeline to drain.
  localparam int PIXEL_TARGET  = 1300;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 150;
  localparam int END_WAIT      = 2000;
  localparam int RUN_LIMIT     = 4000000;

  typedef struct packed {
    logic [PIX_BITS-1:0] pixel;
    logic                last;
  } pixel_beat_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [PIX_BITS-1:0] pixel_in  = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PIX_BITS-1:0] pixel_out;
  logic                frame_end;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_reg_t            cfg_index = REG_SRC_WIDTH;
  logic [CFG_W-1:0]    cfg_data  = '0;

  always #2 clk = ~clk;

  aspect_fit_nearest_downscaler #(
    .MAX_DIM_BITS(DIM_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .PIXEL_BITS  (PIX_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .pixel_in (pixel_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_out(pixel_out),
    .frame_end(frame_end),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Shadow copy of the block: the size registers as written, and the frame
  // position, selection accumulators and latched fit that decide each pixel.
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]  src_w_reg = RST_SRC_WIDTH;
  logic [CFG_W-1:0]  src_h_reg = RST_SRC_HEIGHT;
  logic [CFG_W-1:0]  box_w_reg = RST_BOX_WIDTH;
  logic [CFG_W-1:0]  box_h_reg = RST_BOX_HEIGHT;
  logic [CFG_W-1:0]  col_pos = '0, row_pos = '0;
  logic [CFG_W-1:0]  out_col = '0, out_row = '0;
  logic [CFG_W-1:0]  fit_w = '0, fit_h = '0;
  logic [STEP_W:0]   col_acc = '0, row_acc = '0;
  logic [STEP_W-1:0] col_step = '0, row_step = '0;

  pixel_beat_t         kept_pixels[$];    // forwarded pixels still to come out
  logic [PIX_BITS-1:0] source_pixels[$];  // pixels waiting for the driver

  int pixels_accepted = 0;
  int pixels_queued   = 0;
  int results_checked = 0;
  int frames_closed   = 0;
  int size_writes     = 0;
  int mismatches      = 0;

  logic pressure_armed = 1'b0;  // set once by the stimulus, read by the pacer
  logic pressure_done  = 1'b0;
  logic long_hold_on   = 1'b0;  // receiver is in a long hold; sender keeps going
  logic tx_steady      = 1'b0;
  logic rx_steady      = 1'b0;
  int   gap_left       = 0;
  int   stall_left     = 0;

  // A zero size reads as one and anything past the top is clipped.
  function automatic logic [CFG_W-1:0] clip_size(logic [CFG_W-1:0] v);
    if (v == '0) return CFG_W'(1);
    if (v > DIM_TOP) return DIM_TOP;
    return v;
  endfunction

  // Fixed-point ratio source/fitted, saturated to the step range.
  function automatic logic [STEP_W-1:0] step_for(longint unsigned src,
                                                 longint unsigned fit);
    longint unsigned q;
    q = (src << FRAC_BITS) / fit;
    if (q > STEP_MAX) q = STEP_MAX;
    return q[STEP_W-1:0];
  endfunction

  // Decides one accepted pixel and queues it if the shrink keeps it.
  function automatic void select_pixel(logic [PIX_BITS-1:0] px);
    longint unsigned sw, sh, bw, bh, fw, fh;
    logic            col_hit, row_hit;
    pixel_beat_t     beat;
    sw = clip_size(src_w_reg);
    sh = clip_size(src_h_reg);

    // The fit and the steps are taken only at the top-left of a frame.
    if (col_pos == '0 && row_pos == '0) begin
      bw = clip_size(box_w_reg);
      bh = clip_size(box_h_reg);
      fw = bw;
      fh = bh;
      if (bw * sh > bh * sw) fw = (bh * sw) / sh;
      else if (bw * sh < bh * sw) fh = (bw * sh) / sw;
      if (fw == 0) fw = 1;
      if (fh == 0) fh = 1;
      if (fw > sw) fw = sw;
      if (fh > sh) fh = sh;
      fit_w    = fw[CFG_W-1:0];
      fit_h    = fh[CFG_W-1:0];
      col_step = step_for(sw, fw);
      row_step = step_for(sh, fh);
      col_acc  = '0;
      row_acc  = '0;
      out_col  = '0;
      out_row  = '0;
    end

    col_hit = (out_col < fit_w) && ((col_acc >> FRAC_BITS) == col_pos);
    row_hit = (out_row < fit_h) && ((row_acc >> FRAC_BITS) == row_pos);

    if (col_hit && row_hit) begin
      beat.pixel = px;
      beat.last  = (out_row + 1 == fit_h) && (out_col + 1 == fit_w);
      kept_pixels.push_back(beat);
    end
    if (col_hit) begin
      out_col = out_col + 1'b1;
      col_acc = col_acc + col_step;
    end

    // Rows and frames close on the live source size; a position already at
    // or past the end closes at once.
    if (col_pos + 1 >= sw) begin
      col_pos = '0;
      out_col = '0;
      col_acc = '0;
      if (row_hit) begin
        out_row = out_row + 1'b1;
        row_acc = row_acc + row_step;
      end
      if (row_pos + 1 >= sh) begin
        row_pos = '0;
        out_row = '0;
        row_acc = '0;
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  function automatic void flag_error(string what);
    mismatches++;
    if (mismatches <= 10) $display("ERROR @%0t: %s", $time, what);
  endfunction

  // --------------------------------------------------------------------------
  // Pixel driver. It takes pixels from source_pixels, holds each until the
  // block takes it, and leaves random gaps between beats: mostly none or a
  // few cycles, now and then a long one, and steady stretches without gaps.
  // During a long receiver hold it keeps offering so the block backs up.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : pixel_driver
    int r;
    int g;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        select_pixel(pixel_in);
        pixels_accepted <= pixels_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 && !long_hold_on) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (source_pixels.size() != 0) begin
          pixel_in <= source_pixels.pop_front();
          in_valid <= 1'b1;
          r = $urandom_range(0, 99);
          if (tx_steady || r < 55) g = 0;
          else if (r < 88) g = $urandom_range(1, 3);
          else g = $urandom_range(6, 30);
          gap_left <= g;
          if ($urandom_range(0, 79) == 0) tx_steady <= !tx_steady;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver pacing. Short random stalls, a few long ones, quiet stretches,
  // and one long hold on request while the sender keeps pushing pixels.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_pacer
    int r;
    int hold;
    if (rst) begin
      out_stall     <= 1'b0;
      stall_left    <= 0;
      pressure_done <= 1'b0;
      long_hold_on  <= 1'b0;
      rx_steady     <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (pressure_armed && !pressure_done) begin
        hold = LONG_HOLD;
        pressure_done <= 1'b1;
      end else if (stall_left != 0) begin
        hold = stall_left;
      end else if (rx_steady || r < 70) begin
        hold = 0;
      end else if (r < 93) begin
        hold = $urandom_range(1, 3);
      end else begin
        hold = $urandom_range(8, 40);
      end
      if ($urandom_range(0, 119) == 0) rx_steady <= !rx_steady;
      out_stall    <= (hold != 0);
      stall_left   <= (hold != 0) ? hold - 1 : 0;
      long_hold_on <= (hold > 20);
    end
  end

  // --------------------------------------------------------------------------
  // Output checker. Each beat taken from the block is matched, field by
  // field, against the oldest pixel the shadow model decided to keep.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_checker
    pixel_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (kept_pixels.size() == 0) begin
        flag_error($sformatf("unexpected beat pixel_out=%h frame_end=%b",
                             pixel_out, frame_end));
      end else begin
        want = kept_pixels.pop_front();
        results_checked++;
        if (pixel_out !== want.pixel)
          flag_error($sformatf("beat %0d pixel_out expected %h got %h",
                               results_checked, want.pixel, pixel_out));
        if (frame_end !== want.last)
          flag_error($sformatf("beat %0d frame_end expected %b got %b",
                               results_checked, want.last, frame_end));
        if (want.last) frames_closed++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic offer_pixel(logic [PIX_BITS-1:0] px);
    source_pixels.push_back(px);
    pixels_queued++;
  endtask

  task automatic offer_random(int n);
    repeat (n) offer_pixel($urandom());
  endtask

  // Writes one size register. The shadow copy follows on the handshake;
  // nothing else is in flight, so the order against pixels is clear.
  task automatic write_size(cfg_reg_t idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SRC_WIDTH:  src_w_reg = value;
      REG_SRC_HEIGHT: src_h_reg = value;
      REG_BOX_WIDTH:  box_w_reg = value;
      REG_BOX_HEIGHT: box_h_reg = value;
      default: ;
    endcase
    size_writes++;
  endtask

  // Waits until every queued pixel is in and every kept pixel is out, then
  // lets the pipeline settle, since a dropped pixel leaves nothing to wait on.
  task automatic wait_idle();
    while (pixels_accepted != pixels_queued || kept_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pixels still needed to close the frame in progress under the live size.
  function automatic int frame_remainder();
    int sw, sh, cols_left, rows_left;
    sw = clip_size(src_w_reg);
    sh = clip_size(src_h_reg);
    if (col_pos == '0 && row_pos == '0) return 0;
    cols_left = (col_pos >= sw) ? 1 : sw - col_pos;
    rows_left = (row_pos + 1 >= sh) ? 0 : sh - row_pos - 1;
    return cols_left + rows_left * sw;
  endfunction

  // One random phase: new sizes, then whole frames (finishing any open one
  // first), or now and then a stub of a frame so that the next sizes land
  // mid-frame. Rarely the sizes go toward the top of the range; those
  // frames are only started, and the next phase brings the source back down.
  bit wide_frame_open = 1'b0;

  task automatic random_phase();
    logic [CFG_W-1:0] sw, sh, bw, bh;
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      write_size(REG_SRC_WIDTH,  CFG_W'($urandom_range(0, 8191)));
      write_size(REG_SRC_HEIGHT, CFG_W'($urandom_range(0, 8191)));
      write_size(REG_BOX_WIDTH,  CFG_W'($urandom_range(0, 8191)));
      write_size(REG_BOX_HEIGHT, CFG_W'($urandom_range(0, 8191)));
      wide_frame_open = 1'b1;
      n = $urandom_range(10, 60);
    end else begin
      sw = ($urandom_range(0, 15) == 0) ? '0 : CFG_W'($urandom_range(1, 12));
      sh = ($urandom_range(0, 15) == 0) ? '0 : CFG_W'($urandom_range(1, 8));
      bw = CFG_W'($urandom_range(0, 20));
      bh = CFG_W'($urandom_range(0, 14));
      if (r < 30) begin
        // Box of the source's own shape: steps of exactly one.
        bw = sw;
        bh = sh;
      end
      if (wide_frame_open || $urandom_range(0, 3) != 0) write_size(REG_SRC_WIDTH, sw);
      if (wide_frame_open || $urandom_range(0, 3) != 0) write_size(REG_SRC_HEIGHT, sh);
      if ($urandom_range(0, 3) != 0) write_size(REG_BOX_WIDTH, bw);
      if ($urandom_range(0, 3) != 0) write_size(REG_BOX_HEIGHT, bh);
      wide_frame_open = 1'b0;
      if (r < 20 && r >= 10) n = $urandom_range(1, 40);
      else n = frame_remainder() + $urandom_range(1, 2) *
               clip_size(src_w_reg) * clip_size(src_h_reg);
    end
    offer_random(n);
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes, 640x480 into the same box: every pixel is kept. Pixel
    // extremes and alternating bit patterns go first.
    offer_pixel('0);
    offer_pixel('1);
    offer_pixel(32'h5555_5555);
    offer_pixel(32'hAAAA_AAAA);
    wait_idle();

    // Zero sizes read as one, written mid-frame: the first pixel is past the
    // new end and closes the frame, then every pixel is a 1x1 frame of its
    // own. The box width is far beyond the top and clips.
    write_size(REG_SRC_WIDTH, '0);
    write_size(REG_SRC_HEIGHT, '0);
    write_size(REG_BOX_WIDTH, '1);
    write_size(REG_BOX_HEIGHT, '0);
    offer_random(3);
    wait_idle();

    // A single full-width row into a one-pixel-wide box: the fitted height
    // truncates to zero and is raised to one, and the column step saturates.
    write_size(REG_SRC_WIDTH, '1);
    write_size(REG_SRC_HEIGHT, CFG_W'(1));
    write_size(REG_BOX_WIDTH, CFG_W'(1));
    write_size(REG_BOX_HEIGHT, DIM_TOP);
    offer_random(10);
    wait_idle();

    // Shrinking the width mid-row closes the row and frame on the next pixel.
    write_size(REG_SRC_WIDTH, CFG_W'(3));
    offer_random(3);
    wait_idle();

    // Box larger than the source: the fit is cut back to the source size.
    // Finish the open frame first, then hold the receiver off for a long
    // stretch while a full frame of kept pixels backs the block up.
    write_size(REG_SRC_WIDTH, CFG_W'(12));
    write_size(REG_SRC_HEIGHT, CFG_W'(8));
    write_size(REG_BOX_WIDTH, CFG_W'(20));
    write_size(REG_BOX_HEIGHT, CFG_W'(20));
    offer_random(frame_remainder());
    wait_idle();
    offer_random(12 * 8);
    @(posedge clk);
    pressure_armed <= 1'b1;
    wait_idle();

    while (pixels_queued < PIXEL_TARGET) random_phase();

    // Drain: everything in, then a bounded wait for the last kept pixels.
    while (pixels_accepted != pixels_queued) @(posedge clk);
    for (int i = 0; i < END_WAIT && kept_pixels.size() != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (kept_pixels.size() != 0) begin
      $display("ERROR: %0d kept pixels never came out", kept_pixels.size());
      mismatches += kept_pixels.size();
    end

    $display("Streamed %0d source pixels through %0d size register writes.",
             pixels_accepted, size_writes);
    $display("Checked %0d output pixels closing %0d output frames, %0d errors.",
             results_checked, frames_closed, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a pixel that never comes out ends here.
  initial begin : watchdog
    #(RUN_LIMIT);
    $display("ERROR: run did not finish in time");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/afd_pkg.sv
rtl/core/afd_div.sv
rtl/core/afd_fit.sv
rtl/core/afd_pos.sv
rtl/core/aspect_fit_nearest_downscaler.sv
sim/tb_aspect_fit_nearest_downscaler.sv
